[rtl/text_console_line_buffer_macros.svh]
// Assertion macros shared by the console buffer checker.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef TEXT_CONSOLE_LINE_BUFFER_MACROS_SVH
`define TEXT_CONSOLE_LINE_BUFFER_MACROS_SVH

// Same-cycle implication.
`define TCLB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console buffer check failed");

// Next-cycle implication.
`define TCLB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console buffer check failed");

`endif

[rtl/tclb_pkg.sv]
// Package for the text console line buffer: opcodes, character codes and
// the sequencer state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tclb_pkg;

    // Operation codes carried in the input tuser.
    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_SETPOS = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Saturation limit of the view-top pointer.
    localparam logic [2:0] TOP_MAX = 3'd7;

    // Reset value of the view height register.
    localparam logic [2:0] VIEW_HEIGHT_RST = 3'd4;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT_START,
        ST_EMIT,
        ST_CR,
        ST_LF,
        ST_WRITE,
        ST_FILL,
        ST_STATUS
    } state_t;

endpackage

`default_nettype wire

[rtl/text_console_line_buffer.sv]
// Text console line buffer. One item is taken at a time: a plain put writes
// its glyph and then gives a status result, set position and clear give a status
// result, and a line feed emits the line (one RAM read per line byte, then CR and
// LF) and then writes the glyph when one follows it. The first write into a line
// that was cleared or scrolled out first blanks that line in the character RAM,
// one character per cycle on the single write port. Results leave through
// an output register, so the last result of an item may wait while the next
// item is taken. Depends on tclb_pkg and tclb_ram.
`timescale 1ns / 1ps
`default_nettype none

module text_console_line_buffer #(
    parameter int WIDTH = 16,
    parameter int LINES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration: view_height.
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_wr_data,
    // Input items.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // char_code[7:0], pos_x[12:8], pos_y[16:13], zero
    input  wire logic [1:0]  s_axis_tuser,  // op[1:0]
    // Result items.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // tx_byte[7:0], cur_col[12:8], cur_line[15:13],
                                            // view_top[18:16], zero
    output logic             m_axis_tuser,  // tx_valid
    output logic             m_axis_tlast   // last
);

    localparam int DEPTH = LINES * WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = (LINES > 2) ? $clog2(LINES) : 1;
    localparam int CW    = $clog2(WIDTH);
    localparam int CCW   = $clog2(WIDTH + 1);

    // Physical row of a logical line in the ring.
    function automatic logic [RW-1:0] row_of(input logic [RW-1:0] base,
                                             input logic [RW-1:0] line);
        logic [RW:0] sum;
        sum = {1'b0, base} + {1'b0, line};
        if (sum >= (RW+1)'(LINES))
        begin
            sum = sum - (RW+1)'(LINES);
        end
        return sum[RW-1:0];
    endfunction

    // RAM address of a character cell.
    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                                input logic [CW-1:0] col);
        return AW'(row) * AW'(WIDTH) + AW'(col);
    endfunction

    // Registers.
    tclb_pkg::state_t   state_reg, state_next;
    logic [CCW-1:0]     col_reg, col_next;
    logic [RW-1:0]      line_reg, line_next;
    logic [2:0]         top_reg, top_next;
    logic [RW-1:0]      base_reg, base_next;
    logic [2:0]         vh_reg;
    logic [LINES-1:0]   row_valid_reg, row_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic               store_reg, store_next;
    logic               fed_reg, fed_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [RW-1:0]      emit_row_reg, emit_row_next;
    logic [RW-1:0]      wr_row_reg, wr_row_next;
    logic [CW-1:0]      wr_col_reg, wr_col_next;
    logic [7:0]         char_reg, char_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               out_flag_reg, out_flag_next;
    logic               out_last_reg, out_last_next;
    logic [4:0]         out_col_reg, out_col_next;
    logic [2:0]         out_line_reg, out_line_next;
    logic [2:0]         out_top_reg, out_top_next;

    // Input fields.
    logic [1:0] in_op;
    logic [7:0] in_char;
    logic [4:0] in_px;
    logic [3:0] in_py;
    logic       accept;

    assign in_op   = s_axis_tuser;
    assign in_char = s_axis_tdata[7:0];
    assign in_px   = s_axis_tdata[12:8];
    assign in_py   = s_axis_tdata[16:13];
    assign s_axis_tready = (state_reg == tclb_pkg::ST_IDLE);
    assign accept  = s_axis_tvalid && s_axis_tready;

    // RAM controls.
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [7:0]    ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0]    ram_rd_data;
    logic          slot_free;
    logic          load;

    assign slot_free = !out_valid_reg || m_axis_tready;

    tclb_ram #(
        .DATA_W (8),
        .DEPTH  (DEPTH)
    ) u_char_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Pointer update of a line feed from the current cursor line.
    logic [RW:0]   lf_nl;
    logic          lf_scroll;
    logic [2:0]    lf_bump_top;
    logic [2:0]    lf_scroll_top;
    logic [4:0]    lf_diff;
    logic [RW-1:0] lf_line;
    logic [RW-1:0] lf_base;
    logic [2:0]    lf_top;

    always_comb
    begin
        lf_nl     = {1'b0, line_reg} + (RW+1)'(1);
        lf_scroll = (lf_nl >= (RW+1)'(LINES));
        if ((5'(lf_nl) > 5'(vh_reg)) && (top_reg != tclb_pkg::TOP_MAX))
        begin
            lf_bump_top = top_reg + 3'd1;
        end
        else
        begin
            lf_bump_top = top_reg;
        end
        // Scroll sets the view top to LINES - view_height - 1, clamped to 0..7.
        lf_diff = 5'(LINES - 1) - 5'(vh_reg);
        if (5'(vh_reg) >= 5'(LINES))
        begin
            lf_scroll_top = 3'd0;
        end
        else if (lf_diff > 5'(tclb_pkg::TOP_MAX))
        begin
            lf_scroll_top = tclb_pkg::TOP_MAX;
        end
        else
        begin
            lf_scroll_top = lf_diff[2:0];
        end
        if (lf_scroll)
        begin
            lf_line = RW'(LINES - 1);
            lf_base = (base_reg == RW'(LINES - 1)) ? '0 : base_reg + RW'(1);
            lf_top  = lf_scroll_top;
        end
        else
        begin
            lf_line = lf_nl[RW-1:0];
            lf_base = base_reg;
            lf_top  = lf_bump_top;
        end
    end

    // Decode of an arriving item.
    logic is_break;
    logic do_lf;
    logic do_store;

    assign is_break = (in_char == tclb_pkg::CH_LF) || (in_char == tclb_pkg::CH_CR);
    assign do_lf    = (in_op == tclb_pkg::OP_PUT) && (is_break || (col_reg >= CCW'(WIDTH)));
    assign do_store = (in_op == tclb_pkg::OP_PUT) && !is_break;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tclb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (do_lf)
                    begin
                        state_next = tclb_pkg::ST_EMIT_START;
                    end
                    else if (do_store)
                    begin
                        state_next = tclb_pkg::ST_WRITE;
                    end
                    else
                    begin
                        state_next = tclb_pkg::ST_STATUS;
                    end
                end
            end
            tclb_pkg::ST_EMIT_START:
            begin
                state_next = tclb_pkg::ST_EMIT;
            end
            tclb_pkg::ST_EMIT:
            begin
                if (slot_free && (cnt_reg == CW'(WIDTH - 1)))
                begin
                    state_next = tclb_pkg::ST_CR;
                end
            end
            tclb_pkg::ST_CR:
            begin
                if (slot_free)
                begin
                    state_next = tclb_pkg::ST_LF;
                end
            end
            tclb_pkg::ST_LF:
            begin
                if (slot_free)
                begin
                    state_next = store_reg ? tclb_pkg::ST_WRITE : tclb_pkg::ST_IDLE;
                end
            end
            tclb_pkg::ST_WRITE:
            begin
                if (!row_valid_reg[wr_row_reg])
                begin
                    state_next = tclb_pkg::ST_FILL;
                end
                else
                begin
                    state_next = fed_reg ? tclb_pkg::ST_IDLE : tclb_pkg::ST_STATUS;
                end
            end
            tclb_pkg::ST_FILL:
            begin
                if (cnt_reg == CW'(WIDTH - 1))
                begin
                    state_next = tclb_pkg::ST_WRITE;
                end
            end
            tclb_pkg::ST_STATUS:
            begin
                if (slot_free)
                begin
                    state_next = tclb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tclb_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: RAM accesses and result loads.
    always_comb
    begin
        ram_wr_en     = 1'b0;
        ram_wr_addr   = cell_addr(wr_row_reg, wr_col_reg);
        ram_wr_data   = char_reg;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = cell_addr(emit_row_reg, cnt_reg + CW'(1));
        load          = 1'b0;
        out_byte_next = out_byte_reg;
        out_flag_next = out_flag_reg;
        out_last_next = out_last_reg;
        unique case (state_reg)
            tclb_pkg::ST_EMIT_START:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = cell_addr(emit_row_reg, '0);
            end
            tclb_pkg::ST_EMIT:
            begin
                load          = slot_free;
                ram_rd_en     = slot_free && (cnt_reg != CW'(WIDTH - 1));
                out_byte_next = row_valid_reg[emit_row_reg] ? ram_rd_data : tclb_pkg::CH_SPACE;
                out_flag_next = 1'b1;
                out_last_next = 1'b0;
            end
            tclb_pkg::ST_CR:
            begin
                load          = slot_free;
                out_byte_next = tclb_pkg::CH_CR;
                out_flag_next = 1'b1;
                out_last_next = 1'b0;
            end
            tclb_pkg::ST_LF:
            begin
                load          = slot_free;
                out_byte_next = tclb_pkg::CH_LF;
                out_flag_next = 1'b1;
                out_last_next = 1'b1;
            end
            tclb_pkg::ST_WRITE:
            begin
                ram_wr_en = row_valid_reg[wr_row_reg];
            end
            tclb_pkg::ST_FILL:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = cell_addr(wr_row_reg, cnt_reg);
                ram_wr_data = tclb_pkg::CH_SPACE;
            end
            tclb_pkg::ST_STATUS:
            begin
                load          = slot_free;
                out_byte_next = 8'h00;
                out_flag_next = 1'b0;
                out_last_next = 1'b1;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase

        // A waiting result keeps its payload until the output register is free.
        if (!load)
        begin
            out_byte_next = out_byte_reg;
            out_flag_next = out_flag_reg;
            out_last_next = out_last_reg;
        end
    end

    // Cursor, ring and bookkeeping updates.
    always_comb
    begin
        col_next       = col_reg;
        line_next      = line_reg;
        top_next       = top_reg;
        base_next      = base_reg;
        row_valid_next = row_valid_reg;
        store_next     = store_reg;
        fed_next       = fed_reg;
        cnt_next       = cnt_reg;
        emit_row_next  = emit_row_reg;
        wr_row_next    = wr_row_reg;
        wr_col_next    = wr_col_reg;
        char_next      = char_reg;

        if (accept)
        begin
            store_next    = do_store;
            fed_next      = do_lf;
            char_next     = in_char;
            emit_row_next = row_of(base_reg, line_reg);
            cnt_next      = '0;
            case (in_op)
                tclb_pkg::OP_PUT:
                begin
                    if (do_lf)
                    begin
                        line_next = lf_line;
                        base_next = lf_base;
                        top_next  = lf_top;
                        if (lf_scroll)
                        begin
                            // The row that leaves the top reads as blank from now on.
                            row_valid_next[base_reg] = 1'b0;
                        end
                    end
                    wr_row_next = do_lf ? row_of(lf_base, lf_line) : row_of(base_reg, line_reg);
                    wr_col_next = do_lf ? '0 : col_reg[CW-1:0];
                    if (do_store)
                    begin
                        col_next = do_lf ? CCW'(1) : col_reg + CCW'(1);
                    end
                    else
                    begin
                        col_next = '0;
                    end
                end
                tclb_pkg::OP_SETPOS:
                begin
                    if (6'(in_px) < 6'(WIDTH))
                    begin
                        col_next = CCW'(in_px);
                    end
                    if (5'(in_py) < 5'(LINES))
                    begin
                        line_next = RW'(in_py);
                    end
                end
                tclb_pkg::OP_CLEAR:
                begin
                    col_next       = '0;
                    line_next      = '0;
                    top_next       = '0;
                    base_next      = '0;
                    row_valid_next = '0;
                end
                default:
                begin
                    col_next = col_reg;
                end
            endcase
        end

        // Line byte counter during emission.
        if ((state_reg == tclb_pkg::ST_EMIT) && slot_free)
        begin
            cnt_next = cnt_reg + CW'(1);
        end

        // Blanking sweep of a row before its first glyph.
        if ((state_reg == tclb_pkg::ST_WRITE) && !row_valid_reg[wr_row_reg])
        begin
            cnt_next = '0;
        end
        if (state_reg == tclb_pkg::ST_FILL)
        begin
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(WIDTH - 1))
            begin
                row_valid_next[wr_row_reg] = 1'b1;
            end
        end
    end

    // Output register.
    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
            out_col_next   = 5'(col_reg);
            out_line_next  = 3'(line_reg);
            out_top_next   = top_reg;
        end
        else
        begin
            out_valid_next = out_valid_reg && !m_axis_tready;
            out_col_next   = out_col_reg;
            out_line_next  = out_line_reg;
            out_top_next   = out_top_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tclb_pkg::ST_IDLE;
            col_reg       <= '0;
            line_reg      <= '0;
            top_reg       <= '0;
            base_reg      <= '0;
            vh_reg        <= tclb_pkg::VIEW_HEIGHT_RST;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
            store_reg     <= 1'b0;
            fed_reg       <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            line_reg      <= line_next;
            top_reg       <= top_next;
            base_reg      <= base_next;
            row_valid_reg <= row_valid_next;
            out_valid_reg <= out_valid_next;
            store_reg     <= store_next;
            fed_reg       <= fed_next;
            cnt_reg       <= cnt_next;
            if (cfg_wr_en)
            begin
                vh_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        emit_row_reg <= emit_row_next;
        wr_row_reg   <= wr_row_next;
        wr_col_reg   <= wr_col_next;
        char_reg     <= char_next;
        out_byte_reg <= out_byte_next;
        out_flag_reg <= out_flag_next;
        out_last_reg <= out_last_next;
        out_col_reg  <= out_col_next;
        out_line_reg <= out_line_next;
        out_top_reg  <= out_top_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_top_reg, out_line_reg, out_col_reg, out_byte_reg};
    assign m_axis_tuser  = out_flag_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

[rtl/tclb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tclb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 128
) (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire logic [DATA_W-1:0]         wr_data,
    input  wire logic                      rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic      [DATA_W-1:0]         rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port and registered read port; read data holds while rd_en is low.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/tclb_checker.sv]
// Port-level checker for the text console line buffer, bound to the top level.
// Depends on tclb_pkg and text_console_line_buffer_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_line_buffer_macros.svh"

module tclb_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic        m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // A stalled result keeps its contents.
    `TCLB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // A status result is the single, final result of its item and carries no byte.
    `TCLB_ASSERT_NOW(a_status_form, m_axis_tvalid && !m_axis_tuser, m_axis_tlast && (m_axis_tdata[7:0] == 8'h00))

    // The final byte of a transmitted line is always the line feed.
    `TCLB_ASSERT_NOW(a_line_end, m_axis_tvalid && m_axis_tuser && m_axis_tlast, m_axis_tdata[7:0] == tclb_pkg::CH_LF)

    // One item at a time: the block is busy right after taking an item.
    `TCLB_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind text_console_line_buffer tclb_checker u_tclb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
